// ----- sv/rrps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared types and constants of the round-robin process scheduler.
// ----------------------------------------------------------------------------
package rrps_pkg;

  localparam int unsigned DEF_MAX_PROCS = 16;

  localparam int unsigned ID_W  = 8;
  localparam int unsigned REM_W = 16;
  localparam int unsigned Q_W   = 8;

  localparam logic [Q_W-1:0] QUANTUM_RST = 8'd3;
  localparam logic [Q_W-1:0] SLICE_MAX   = 8'd255;

  // item kinds
  localparam logic MODE_ENQ  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [REM_W-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic            ran;
    logic [ID_W-1:0] run_id;
    logic            finished;
    logic            rotated;
    logic            rejected;
  } result_t;

endpackage

// ----- sv/rrps_queue_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_queue_mem
// Process table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rrps_queue_mem
  import rrps_pkg::*;
#(
  parameter int unsigned DEPTH  = DEF_MAX_PROCS,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/rrps_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_out_buf
// Two-deep result queue between the scheduler core and the output channel.
// ----------------------------------------------------------------------------
module rrps_out_buf
  import rrps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t    slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop        = out_valid && out_ready;
  assign wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_res;
    end
  end

  assign space     = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = slot_r[rd_ptr_r];

endmodule

// ----- sv/rrps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_ctrl
// Scheduler core: queue pointers, slice counter, read-modify-write sequencing.
// ----------------------------------------------------------------------------
module rrps_ctrl
  import rrps_pkg::*;
#(
  parameter int unsigned MAX_PROCS = DEF_MAX_PROCS,
  parameter int unsigned PTR_W     = $clog2(MAX_PROCS),
  parameter int unsigned CNT_W     = $clog2(MAX_PROCS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  // item channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [ID_W-1:0]  in_process_id,
  input  logic [REM_W-1:0] in_burst_length,
  // quantum register write
  input  logic             cfg_valid,
  input  logic [Q_W-1:0]   cfg_quantum,
  // table
  output logic             mem_we,
  output logic [PTR_W-1:0] mem_waddr,
  output entry_t           mem_wdata,
  output logic             mem_re,
  output logic [PTR_W-1:0] mem_raddr,
  input  entry_t           mem_rdata,
  // result queue
  input  logic             buf_space,
  output logic             res_push,
  output result_t          res
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(MAX_PROCS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PROCS);

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [Q_W-1:0]     slice_r, slice_nxt;
  logic [Q_W-1:0]     quantum_r;
  logic               mode_r;
  logic [ID_W-1:0]    pid_r;
  logic [REM_W-1:0]   burst_r;

  logic               accept;
  logic [PTR_W-1:0]   head_inc, tail_inc;
  logic [REM_W-1:0]   rem_dec;
  logic [Q_W-1:0]     slice_inc;

  assign in_ready  = (state_r == S_IDLE) && buf_space;
  assign accept    = in_valid && in_ready;
  assign mem_re    = accept;
  assign mem_raddr = head_r;

  assign head_inc  = (head_r == LAST_POS) ? '0 : head_r + PTR_W'(1);
  assign tail_inc  = (tail_r == LAST_POS) ? '0 : tail_r + PTR_W'(1);
  assign rem_dec   = (mem_rdata.rem != '0) ? mem_rdata.rem - REM_W'(1) : '0;
  assign slice_inc = (slice_r != SLICE_MAX) ? slice_r + Q_W'(1) : slice_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    slice_nxt = slice_r;
    mem_we    = 1'b0;
    mem_waddr = head_r;
    mem_wdata = '{id: mem_rdata.id, rem: rem_dec};
    res_push  = 1'b0;
    res       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        res_push  = 1'b1;
        if (mode_r == MODE_ENQ) begin
          if (count_r == FULL_CNT || burst_r == '0) begin
            res.rejected = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = tail_r;
            mem_wdata = '{id: pid_r, rem: burst_r};
            tail_nxt  = tail_inc;
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (count_r != '0) begin
          res.ran    = 1'b1;
          res.run_id = mem_rdata.id;
          if (rem_dec == '0) begin
            // done: leaves the queue, no write-back needed
            res.finished = 1'b1;
            head_nxt     = head_inc;
            count_nxt    = count_r - CNT_W'(1);
            slice_nxt    = '0;
          end else if (quantum_r != '0 && slice_inc >= quantum_r) begin
            // slice used up: move entry to the tail
            res.rotated = 1'b1;
            mem_we      = 1'b1;
            mem_waddr   = tail_r;
            tail_nxt    = tail_inc;
            head_nxt    = head_inc;
            slice_nxt   = '0;
          end else begin
            mem_we    = 1'b1;
            slice_nxt = slice_inc;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      slice_r   <= '0;
      quantum_r <= QUANTUM_RST;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      slice_r <= slice_nxt;
      if (cfg_valid) begin
        quantum_r <= cfg_quantum;
      end
      if (accept) begin
        mode_r  <= in_mode;
        pid_r   <= in_process_id;
        burst_r <= in_burst_length;
      end
    end
  end

endmodule

// ----- sv/round_robin_process_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_process_scheduler
// Round-robin time-slice scheduler over a circular queue of processes.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake         | Beat contents
//  --------+-----------+-------------------+----------------------------------
//  in_     | input     | in_valid/in_ready | mode, process_id, burst_length
//  out_    | output    | out_valid/ready   | ran, run_id, finished, rotated,
//          |           |                   | rejected
//  cfg_    | input     | cfg_valid/ready   | quantum (slice length, 0 = batch)
//
//  Each item is a read-modify-write: the head entry is read from the process
//  table (synchronous read) and modified and written back in the next cycle,
//  so one item is in flight at a time and the next is taken right after.
//  Results go to a 2-deep queue; input also waits while that queue is full.
//  Reset (rst_n low, synchronous) empties the queue, clears the slice count
//  and sets quantum to 3. The table itself is not cleared; it needs none.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module round_robin_process_scheduler
  import rrps_pkg::*;
#(
  parameter int unsigned MAX_PROCS = DEF_MAX_PROCS
) (
  input  logic             clk,
  input  logic             rst_n,
  // item channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [ID_W-1:0]  in_process_id,
  input  logic [REM_W-1:0] in_burst_length,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_ran,
  output logic [ID_W-1:0]  out_run_id,
  output logic             out_finished,
  output logic             out_rotated,
  output logic             out_rejected,
  // quantum register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [Q_W-1:0]   cfg_quantum
);

  localparam int unsigned PTR_W = $clog2(MAX_PROCS);

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  entry_t           mem_rdata;
  logic             buf_space;
  logic             res_push;
  result_t          res;
  result_t          out_res;

  assign cfg_ready = 1'b1;

  // pointers, slice counter and the read-modify-write sequence
  rrps_ctrl #(
    .MAX_PROCS (MAX_PROCS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_process_id   (in_process_id),
    .in_burst_length (in_burst_length),
    .cfg_valid       (cfg_valid),
    .cfg_quantum     (cfg_quantum),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .buf_space       (buf_space),
    .res_push        (res_push),
    .res             (res)
  );

  // id and remaining work per queue slot
  rrps_queue_mem #(
    .DEPTH (MAX_PROCS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // decouples result delivery from the core
  rrps_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_res  (res),
    .space     (buf_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_ran      = out_res.ran;
  assign out_run_id   = out_res.run_id;
  assign out_finished = out_res.finished;
  assign out_rotated  = out_res.rotated;
  assign out_rejected = out_res.rejected;

endmodule

// ----- sv/rrps_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrps_checker
  import rrps_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_ran,
  input logic [ID_W-1:0] out_run_id,
  input logic            out_finished,
  input logic            out_rotated,
  input logic            out_rejected
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ran) && $stable(out_run_id)
      && $stable(out_finished) && $stable(out_rotated) && $stable(out_rejected))
    else $error("result beat changed while stalled");

  // completion and rotation exclude each other
  a_fin_rot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_finished && out_rotated))
    else $error("finished and rotated both set");

  // a refused enqueue runs nothing
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> !out_ran)
    else $error("rejected beat reports a run");

  // no run means a clean result
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ran |-> !out_finished && !out_rotated && out_run_id == '0)
    else $error("no-run beat carries run fields");

  // one item in flight: input is closed in the cycle after each accepted beat
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

endmodule

bind round_robin_process_scheduler rrps_checker u_rrps_checker (.*);

// ----- dv/round_robin_process_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_process_scheduler_tb
// Self-checking testbench of the round-robin process scheduler.
// Directed scenarios (idle tick, refused enqueues, full queue, lone rotation,
// slice saturation in batch mode, quantum lowered mid-slice), a back-pressure
// run, then random phases across quantum settings. Every result beat is
// checked field by field against a cycle-free scheduler predictor.
// ----------------------------------------------------------------------------
module round_robin_process_scheduler_tb;
  import rrps_pkg::*;

  localparam int unsigned DEPTH       = DEF_MAX_PROCS;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned GAP_MAX     = 17;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned PHASES      = 10;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports. All inputs start at known values.
  // --------------------------------------------------------------------------
  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_ready;
  logic             in_mode         = MODE_ENQ;
  logic [ID_W-1:0]  in_process_id   = '0;
  logic [REM_W-1:0] in_burst_length = '0;
  logic             out_valid;
  logic             out_ready       = 1'b0;
  logic             out_ran;
  logic [ID_W-1:0]  out_run_id;
  logic             out_finished;
  logic             out_rotated;
  logic             out_rejected;
  logic             cfg_valid       = 1'b0;
  logic             cfg_ready;
  logic [Q_W-1:0]   cfg_quantum     = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  round_robin_process_scheduler u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_process_id   (in_process_id),
    .in_burst_length (in_burst_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ran         (out_ran),
    .out_run_id      (out_run_id),
    .out_finished    (out_finished),
    .out_rotated     (out_rotated),
    .out_rejected    (out_rejected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_quantum     (cfg_quantum)
  );

  // --------------------------------------------------------------------------
  // Scheduler predictor state: a private copy of the process queue, the
  // slice counter and the quantum register, at the block's widths.
  // --------------------------------------------------------------------------
  logic [ID_W-1:0]  sched_ids [DEPTH];
  logic [REM_W-1:0] sched_rem [DEPTH];
  int unsigned      sched_head    = 0;
  int unsigned      sched_tail    = 0;
  int unsigned      sched_count   = 0;
  logic [Q_W-1:0]   sched_slice   = '0;
  logic [Q_W-1:0]   sched_quantum = QUANTUM_RST;

  // results predicted but not yet seen on the output channel, oldest first
  result_t pending_results[$];

  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned n_ticks      = 0;
  int unsigned n_enqueues   = 0;
  int unsigned n_refused    = 0;
  int unsigned n_finished   = 0;
  int unsigned n_rotated    = 0;
  int unsigned n_cfg_writes = 0;

  // idle shaping: quiet sides never insert gaps; a hold request makes the
  // receiver drop ready for the requested hold at its next beat boundary
  bit src_quiet     = 1'b0;
  bit snk_quiet     = 1'b0;
  int sink_hold_req = 0;

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted item and returns the result it causes.
  // --------------------------------------------------------------------------
  function automatic result_t predict_schedule(input logic             mode,
                                               input logic [ID_W-1:0]  pid,
                                               input logic [REM_W-1:0] burst);
    result_t          r;
    int unsigned      h;
    logic [REM_W-1:0] rem;
    r = '0;
    if (mode == MODE_ENQ) begin
      // full queue or zero work: refused, nothing stored
      if (sched_count >= DEPTH || burst == '0) begin
        r.rejected = 1'b1;
      end else begin
        sched_ids[sched_tail] = pid;
        sched_rem[sched_tail] = burst;
        sched_tail = (sched_tail + 1) % DEPTH;
        sched_count++;
      end
    end else if (sched_count != 0) begin
      h        = sched_head;
      rem      = sched_rem[h];
      r.ran    = 1'b1;
      r.run_id = sched_ids[h];
      if (rem != '0) rem--;
      sched_rem[h] = rem;
      // batch mode keeps counting but never wraps
      if (sched_slice != SLICE_MAX) sched_slice++;
      if (rem == '0) begin
        // completion wins over rotation
        r.finished  = 1'b1;
        sched_head  = (h + 1) % DEPTH;
        sched_count--;
        sched_slice = '0;
      end else if (sched_quantum != '0 && sched_slice >= sched_quantum) begin
        // slice used up: head goes to the tail (onto itself when alone)
        r.rotated             = 1'b1;
        sched_ids[sched_tail] = sched_ids[h];
        sched_rem[sched_tail] = rem;
        sched_tail            = (sched_tail + 1) % DEPTH;
        sched_head            = (h + 1) % DEPTH;
        sched_slice           = '0;
      end
    end
    // an idle tick leaves everything at zero
    return r;
  endfunction

  function automatic int pick_gap(input bit quiet);
    if (quiet) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, GAP_MAX);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Sender: one input beat. Inputs change on the falling edge; acceptance is
  // seen on the rising edge. Valid stays up between back-to-back beats.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic             mode,
                           input logic [ID_W-1:0]  pid,
                           input logic [REM_W-1:0] burst);
    int      gap;
    result_t want;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_process_id   <= pid;
    in_burst_length <= burst;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    want = predict_schedule(mode, pid, burst);
    pending_results.insert(pending_results.size(), want);
    if (mode == MODE_TICK) n_ticks++;
    else n_enqueues++;
    if (want.rejected) n_refused++;
    if (want.finished) n_finished++;
    if (want.rotated)  n_rotated++;
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, ID_W'($urandom_range(0, 255)), REM_W'($urandom_range(0, 65535)));
  endtask

  // Random beat: enqueues carry small bursts (some zero) so processes come
  // and go; on a full queue the burst spans the whole field and is refused.
  task automatic send_random_item(input int unsigned enq_pct);
    logic [ID_W-1:0]  pid;
    logic [REM_W-1:0] burst;
    pid = ID_W'($urandom_range(0, 255));
    if ($urandom_range(1, 100) <= enq_pct) begin
      if (sched_count >= DEPTH) burst = REM_W'($urandom_range(0, 65535));
      else if ($urandom_range(0, 11) == 0) burst = '0;
      else burst = REM_W'($urandom_range(1, 9));
      send_item(MODE_ENQ, pid, burst);
    end else begin
      send_tick();
    end
  endtask

  // Stop offering beats and wait until every predicted result has come out,
  // then let the read-modify-write pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Quantum write; only called with the block idle.
  task automatic set_quantum(input logic [Q_W-1:0] q);
    @(negedge clk);
    cfg_valid   <= 1'b1;
    cfg_quantum <= q;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sched_quantum = q;
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: per beat draws a stall, or serves a pending long hold-off.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = pick_gap(snk_quiet);
      if (sink_hold_req != 0) begin
        stall         = sink_hold_req;
        sink_hold_req = 0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every result beat against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ran !== want.ran)           report_mismatch("ran", out_ran, want.ran);
        if (out_run_id !== want.run_id)     report_mismatch("run_id", out_run_id, want.run_id);
        if (out_finished !== want.finished) report_mismatch("finished", out_finished, want.finished);
        if (out_rotated !== want.rotated)   report_mismatch("rotated", out_rotated, want.rotated);
        if (out_rejected !== want.rejected) report_mismatch("rejected", out_rejected, want.rejected);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset quantum (3): idle tick, zero-burst refusal, extreme ids, a lone
  // process rotating onto itself, and an enqueue at the start of a fresh slice.
  task automatic test_directed_basics();
    send_item(MODE_TICK, 8'hFF, 16'hFFFF);   // empty queue: all zero
    send_item(MODE_ENQ, 8'h00, 16'h0000);    // zero burst: refused
    send_item(MODE_ENQ, 8'hFF, 16'd1);
    send_tick();                             // finishes at once
    send_item(MODE_ENQ, 8'h00, 16'd4);
    repeat (3) send_tick();                  // lone process rotates on itself
    send_item(MODE_ENQ, 8'h5A, 16'd1);       // slice count untouched
    repeat (3) send_tick();
  endtask

  // Quantum 1: fill every slot, refuse one more with an all-ones burst,
  // then run three ticks against the full queue.
  task automatic test_full_queue();
    wait_idle();
    set_quantum(8'd1);
    for (int i = 0; i < DEPTH; i++) begin
      send_item(MODE_ENQ, ID_W'(8'hA0 + i), REM_W'(1 + (i % 3)));
    end
    send_item(MODE_ENQ, 8'hAA, 16'hFFFF);    // full: refused
    repeat (3) send_tick();
  endtask

  // Batch mode: drain the queue, run one long process until the slice
  // counter saturates, then lower the quantum below it mid-slice.
  task automatic test_slice_saturation();
    wait_idle();
    set_quantum(8'd0);
    while (sched_count != 0) send_tick();
    send_item(MODE_ENQ, 8'h81, 16'd300);
    while (sched_slice != SLICE_MAX) send_tick();
    repeat (3) send_tick();                  // stays at the ceiling
    wait_idle();
    set_quantum(8'd4);
    repeat (2) send_tick();                  // rotates on the first tick
  endtask

  // Receiver holds off for a long stretch while the sender streams, so the
  // result queue fills and the input stalls; then, after a pause, ten beats with gaps.
  task automatic test_backpressure();
    wait_idle();
    src_quiet     = 1'b1;
    sink_hold_req = 150;
    repeat (40) send_random_item(55);
    wait_idle();
    src_quiet = 1'b0;
    repeat (10) send_random_item(50);
  endtask

  // Random phases over a spread of quanta, the extremes included; phases
  // alternate between filling and draining the queue, and the idle pattern
  // of both sides is redrawn every 25 beats.
  task automatic test_random_mix();
    logic [Q_W-1:0] quanta[PHASES];
    int unsigned    per_phase;
    quanta    = '{8'd2, 8'd255, 8'd0, 8'd1, 8'd3, 8'd7, 8'd0, 8'd255, 8'd5, 8'd1};
    per_phase = RANDOM_ITEMS / PHASES;
    quanta[4] = Q_W'($urandom_range(1, 254));
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      set_quantum(quanta[p]);
      for (int i = 0; i < per_phase; i++) begin
        if (i % 25 == 0) begin
          src_quiet = ($urandom_range(0, 3) == 0);
          snk_quiet = ($urandom_range(0, 3) == 0);
        end
        send_random_item((p % 2 == 0) ? 60 : 40);
      end
    end
    src_quiet = 1'b0;
    snk_quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main_flow
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_basics();
    test_full_queue();
    test_slice_saturation();
    test_backpressure();
    test_random_mix();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d ticks and %0d enqueues (%0d refused): %0d completions, %0d rotations",
             n_ticks, n_enqueues, n_refused, n_finished, n_rotated);
    $display("%0d quantum writes, batch and 255 included; %0d mismatches in %0d cycles",
             n_cfg_writes, error_count, cycle_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- round_robin_process_scheduler.f -----
sv/rrps_pkg.sv
sv/rrps_queue_mem.sv
sv/rrps_out_buf.sv
sv/rrps_ctrl.sv
sv/round_robin_process_scheduler.sv
sv/rrps_checker.sv
dv/round_robin_process_scheduler_tb.sv
